### rtl/spq_pkg.sv
package spq_pkg;

    localparam int CAPACITY = 256;
    localparam int PTR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 32;
    localparam int TAG_W    = 16;
    localparam int COUNT_W  = 9;
    localparam int ERR_W    = 2;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_FULL  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd2;

    typedef logic [PTR_W-1:0] ptr_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } entry_t;

    typedef struct packed {
        logic             mode;
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } cmd_t;

    typedef struct packed {
        logic [TAG_W-1:0]   head_tag;
        logic [KEY_W-1:0]   head_key;
        logic [COUNT_W-1:0] count;
        logic               empty;
        logic [ERR_W-1:0]   err;
    } result_t;

    // Circular buffer: logical index relative to the head pointer
    function automatic ptr_t phys(input ptr_t base, input cnt_t lidx);
        logic [CNT_W:0] sum;
        sum = {1'b0, (CNT_W)'(base)} + {1'b0, lidx};
        if (sum >= (CNT_W + 1)'(CAPACITY))
        begin
            sum = sum - (CNT_W + 1)'(CAPACITY);
        end
        return PTR_W'(sum);
    endfunction

endpackage

### rtl/spq_if.sv
interface spq_req_if;
    logic                      valid;
    logic                      ready;
    logic                      mode;
    logic [spq_pkg::KEY_W-1:0] priority_req;
    logic [spq_pkg::TAG_W-1:0] payload;

    modport source (output valid, mode, priority_req, payload, input ready);
    modport sink (input valid, mode, priority_req, payload, output ready);
endinterface

interface spq_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [spq_pkg::TAG_W-1:0]   head_payload;
    logic [spq_pkg::KEY_W-1:0]   head_priority;
    logic [spq_pkg::COUNT_W-1:0] count;
    logic                        empty_res;
    logic [spq_pkg::ERR_W-1:0]   error;

    modport source (output valid, head_payload, head_priority, count, empty_res, error,
                    input ready);
    modport sink (input valid, head_payload, head_priority, count, empty_res, error,
                  output ready);
endinterface

### rtl/sorted_priority_queue.sv
// Channel  Dir  Transaction
// req      in   mode, priority_req, payload (insert or remove head)
// rsp      out  head_payload, head_priority, count, empty_res, error
//
// Entries sit in one RAM as a circular buffer; a remove advances the head pointer.
// Remove: IDLE, HEAD_WAIT, DONE; the last entry skips HEAD_WAIT. Refused: IDLE, DONE.
// Insert: scan probes (SCAN_RD, SCAN_CMP) alternating from both ends, then SH_RD and
// SH_WR per entry shifted toward the tail, then WR_NEW, all set by the single RAM port
// pair. req.ready is low while an operation runs.
// A finished result waits in the rsp register; the next req is taken meanwhile.
// Reset clears count and head pointer at once; no clearing pass.
module sorted_priority_queue (
    input  logic            clk,
    input  logic            rst_n,
    spq_req_if.sink         req,
    spq_rsp_if.source       rsp
);
    import spq_pkg::*;

    cmd_t    cmd;
    logic    cmd_ready;
    logic    res_valid;
    logic    res_free;
    result_t res;
    result_t res_reg;
    logic    out_valid_reg;

    logic   ram_we;
    ptr_t   ram_waddr;
    entry_t ram_wdata;
    ptr_t   ram_raddr;
    entry_t ram_rdata;

    assign cmd.mode  = req.mode;
    assign cmd.key   = req.priority_req;
    assign cmd.tag   = req.payload;
    assign req.ready = cmd_ready;

    assign res_free = !out_valid_reg || rsp.ready;

    spq_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (req.valid),
        .cmd       (cmd),
        .cmd_ready (cmd_ready),
        .res_free  (res_free),
        .res_valid (res_valid),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    spq_ram #(
        .DEPTH  (CAPACITY),
        .WIDTH  ($bits(entry_t)),
        .ADDR_W (PTR_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            res_reg <= res;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.head_payload  = res_reg.head_tag;
    assign rsp.head_priority = res_reg.head_key;
    assign rsp.count         = res_reg.count;
    assign rsp.empty_res     = res_reg.empty;
    assign rsp.error         = res_reg.err;

endmodule

### rtl/spq_ram.sv
module spq_ram #(
    parameter int DEPTH  = 256,
    parameter int WIDTH  = 48,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/spq_seq.sv
module spq_seq (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    input  spq_pkg::cmd_t    cmd,
    output logic             cmd_ready,
    input  logic             res_free,
    output logic             res_valid,
    output spq_pkg::result_t res,
    output logic             ram_we,
    output spq_pkg::ptr_t    ram_waddr,
    output spq_pkg::entry_t  ram_wdata,
    output spq_pkg::ptr_t    ram_raddr,
    input  spq_pkg::entry_t  ram_rdata
);
    import spq_pkg::*;

    typedef enum logic [2:0] {
        IDLE,
        SCAN_RD,
        SCAN_CMP,
        SH_RD,
        SH_WR,
        WR_NEW,
        HEAD_WAIT,
        DONE
    } state_t;

    state_t           state_reg, state_next;
    cnt_t             cnt_reg, cnt_next;
    ptr_t             head_ptr_reg, head_ptr_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [TAG_W-1:0] tag_reg, tag_next;
    ptr_t             front_reg, front_next;
    ptr_t             back_reg, back_next;
    logic             front_ph_reg, front_ph_next;
    ptr_t             pos_reg, pos_next;
    ptr_t             j_reg, j_next;
    logic [ERR_W-1:0] err_reg, err_next;
    logic [KEY_W-1:0] hkey_reg, hkey_next;
    logic [TAG_W-1:0] htag_reg, htag_next;

    logic list_empty;

    assign list_empty = (cnt_reg == '0);
    assign cmd_ready  = (state_reg == IDLE);
    assign res_valid  = (state_reg == DONE) && res_free;

    assign res.head_tag = list_empty ? '0 : htag_reg;
    assign res.head_key = list_empty ? '0 : hkey_reg;
    assign res.count    = COUNT_W'(cnt_reg);
    assign res.empty    = list_empty;
    assign res.err      = err_reg;

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        head_ptr_next = head_ptr_reg;
        key_next      = key_reg;
        tag_next      = tag_reg;
        front_next    = front_reg;
        back_next     = back_reg;
        front_ph_next = front_ph_reg;
        pos_next      = pos_reg;
        j_next        = j_reg;
        err_next      = err_reg;
        hkey_next     = hkey_reg;
        htag_next     = htag_reg;
        ram_we        = 1'b0;
        ram_waddr     = phys(head_ptr_reg, cnt_t'(pos_reg));
        ram_wdata     = '{key: key_reg, tag: tag_reg};
        ram_raddr     = phys(head_ptr_reg, '0);

        unique case (state_reg)
            IDLE:
            begin
                if (cmd_valid)
                begin
                    key_next = cmd.key;
                    tag_next = cmd.tag;
                    err_next = ERR_OK;
                    if (cmd.mode == MODE_REMOVE)
                    begin
                        if (list_empty)
                        begin
                            err_next   = ERR_EMPTY;
                            state_next = DONE;
                        end
                        else
                        begin
                            head_ptr_next = phys(head_ptr_reg, cnt_t'(1));
                            cnt_next      = cnt_reg - cnt_t'(1);
                            // new head is read in HEAD_WAIT via the read below
                            ram_raddr     = phys(head_ptr_reg, cnt_t'(1));
                            state_next    = (cnt_reg == cnt_t'(1)) ? DONE : HEAD_WAIT;
                        end
                    end
                    else if (cnt_reg == cnt_t'(CAPACITY))
                    begin
                        err_next   = ERR_FULL;
                        state_next = DONE;
                    end
                    else if (list_empty)
                    begin
                        pos_next   = '0;
                        state_next = WR_NEW;
                    end
                    else
                    begin
                        front_next    = '0;
                        back_next     = ptr_t'(cnt_reg - cnt_t'(1));
                        front_ph_next = 1'b1;
                        state_next    = SCAN_RD;
                    end
                end
            end

            SCAN_RD:
            begin
                ram_raddr  = phys(head_ptr_reg,
                                  cnt_t'(front_ph_reg ? front_reg : back_reg));
                state_next = SCAN_CMP;
            end

            SCAN_CMP:
            begin
                state_next    = SCAN_RD;
                front_ph_next = !front_ph_reg;
                if (front_ph_reg)
                begin
                    if (key_reg <= ram_rdata.key)
                    begin
                        pos_next   = front_reg;
                        state_next = SH_RD;
                    end
                    else
                    begin
                        front_next = front_reg + ptr_t'(1);
                    end
                end
                else
                begin
                    if (key_reg >= ram_rdata.key)
                    begin
                        pos_next   = back_reg + ptr_t'(1);
                        state_next = SH_RD;
                    end
                    else
                    begin
                        back_next = back_reg - ptr_t'(1);
                    end
                end
                if (state_next == SH_RD)
                begin
                    j_next = ptr_t'(cnt_reg - cnt_t'(1));
                    if (pos_next == ptr_t'(cnt_reg))
                    begin
                        state_next = WR_NEW;
                    end
                end
            end

            SH_RD:
            begin
                ram_raddr  = phys(head_ptr_reg, cnt_t'(j_reg));
                state_next = SH_WR;
            end

            SH_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = phys(head_ptr_reg, cnt_t'(j_reg) + cnt_t'(1));
                ram_wdata = ram_rdata;
                if (j_reg == pos_reg)
                begin
                    state_next = WR_NEW;
                end
                else
                begin
                    j_next     = j_reg - ptr_t'(1);
                    state_next = SH_RD;
                end
            end

            WR_NEW:
            begin
                ram_we   = 1'b1;
                cnt_next = cnt_reg + cnt_t'(1);
                if (pos_reg == '0)
                begin
                    hkey_next = key_reg;
                    htag_next = tag_reg;
                end
                state_next = DONE;
            end

            HEAD_WAIT:
            begin
                hkey_next  = ram_rdata.key;
                htag_next  = ram_rdata.tag;
                state_next = DONE;
            end

            DONE:
            begin
                if (res_free)
                begin
                    state_next = IDLE;
                end
            end

            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= IDLE;
            cnt_reg      <= '0;
            head_ptr_reg <= '0;
            front_ph_reg <= 1'b1;
            err_reg      <= ERR_OK;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            head_ptr_reg <= head_ptr_next;
            front_ph_reg <= front_ph_next;
            err_reg      <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        tag_reg   <= tag_next;
        front_reg <= front_next;
        back_reg  <= back_next;
        pos_reg   <= pos_next;
        j_reg     <= j_next;
        hkey_reg  <= hkey_next;
        htag_reg  <= htag_next;
    end

endmodule
